>>> hdl/ths_pkg.sv
// Shared types, codes and helpers for the typed handle store.
package ths_pkg;

    // Table geometry
    localparam int SLOTS   = 16;
    localparam int SLOT_AW = $clog2(SLOTS);

    // Field widths
    localparam int REQ_W    = 3;
    localparam int HANDLE_W = 32;
    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = HANDLE_W + KIND_W + VALUE_W;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_CREATE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FREE   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_GETTYP = 3'd4;

    // Value kinds
    localparam logic [KIND_W-1:0] KIND_U8  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_U16 = 3'd1;
    localparam logic [KIND_W-1:0] KIND_U32 = 3'd2;
    localparam logic [KIND_W-1:0] KIND_U64 = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STR = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ALLOC = 2'd2;

    localparam logic [HANDLE_W-1:0] HANDLE_MAX = '1;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;    // capture request, restart scan
        logic scan;    // issue one slot read, advance scan index
        logic finish;  // apply request, launch result beat
    } t_ths_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic last;    // scan index sits on the final slot
    } t_ths_sts;

    // Keep mask for a stored value of the given kind
    function automatic logic [VALUE_W-1:0] kind_mask(input logic [KIND_W-1:0] kind);
        logic [VALUE_W-1:0] m;
        case (kind)
            KIND_U8:  m = 64'h0000_0000_0000_00FF;
            KIND_U16: m = 64'h0000_0000_0000_FFFF;
            KIND_U32: m = 64'h0000_0000_FFFF_FFFF;
            default:  m = '1;
        endcase
        return m;
    endfunction

endpackage

>>> hdl/ths_ram.sv
// Generic simple dual-port RAM with registered read.
module ths_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/ths_ctrl.sv
// Sequencer for the typed handle store: accept, scan, drain, finish.
module ths_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ths_pkg::t_ths_sts i_sts,
    output ths_pkg::t_ths_cmd o_cmd,
    output logic              o_busy
);
    import ths_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    // Take a new request in idle or while the previous one finishes
    assign o_busy = (r_state == S_SCAN) || (r_state == S_DRAIN);
    assign accept = i_start && !o_busy;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd.load   = accept;
        o_cmd.scan   = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = accept ? S_SCAN : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/ths_dp.sv
// Datapath for the typed handle store: slot RAM, scan compare, request apply.
module ths_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ths_pkg::t_ths_cmd                i_cmd,
    output ths_pkg::t_ths_sts                o_sts,
    input  logic [ths_pkg::REQ_W-1:0]        i_req_type,
    input  logic [ths_pkg::HANDLE_W-1:0]     i_obj_handle,
    input  logic [ths_pkg::KIND_W-1:0]       i_value_kind,
    input  logic [ths_pkg::VALUE_W-1:0]      i_write_value,
    output logic                             o_valid,
    output logic [ths_pkg::VALUE_W-1:0]      o_read_value,
    output logic [ths_pkg::HANDLE_W-1:0]     o_new_handle,
    output logic [ths_pkg::KIND_W-1:0]       o_found_kind,
    output logic [ths_pkg::STATUS_W-1:0]     o_status
);
    import ths_pkg::*;

    // Captured request
    logic [REQ_W-1:0]    r_req;
    logic [HANDLE_W-1:0] r_hnd;
    logic [KIND_W-1:0]   r_kind;
    logic [VALUE_W-1:0]  r_wval;

    // Scan state
    logic [SLOT_AW-1:0]  r_idx;
    logic [SLOT_AW-1:0]  r_cmp_idx;
    logic                r_rd_vld;
    logic                r_hit;
    logic [SLOT_AW-1:0]  r_hit_idx;
    logic [KIND_W-1:0]   r_hit_kind;
    logic [VALUE_W-1:0]  r_hit_val;
    logic                r_free;
    logic [SLOT_AW-1:0]  r_free_idx;

    // Table state
    logic [SLOTS-1:0]    r_valid;
    logic [HANDLE_W-1:0] r_counter;

    // Result registers
    logic                r_out_vld;
    logic [VALUE_W-1:0]  r_out_rval;
    logic [HANDLE_W-1:0] r_out_nh;
    logic [KIND_W-1:0]   r_out_fk;
    logic [STATUS_W-1:0] r_out_st;

    // RAM ports
    logic                we;
    logic [SLOT_AW-1:0]  waddr;
    logic [ENTRY_W-1:0]  wdata;
    logic [ENTRY_W-1:0]  rdata;
    logic [HANDLE_W-1:0] rd_handle;
    logic [KIND_W-1:0]   rd_kind;
    logic [VALUE_W-1:0]  rd_value;

    // Apply decisions
    logic                alloc_ok;
    logic                access_ok;
    logic                set_valid;
    logic                clr_valid;
    logic [HANDLE_W-1:0] n_counter;
    logic [VALUE_W-1:0]  n_rval;
    logic [HANDLE_W-1:0] n_nh;
    logic [KIND_W-1:0]   n_fk;
    logic [STATUS_W-1:0] n_st;

    ths_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    assign rd_handle = rdata[ENTRY_W-1 -: HANDLE_W];
    assign rd_kind   = rdata[VALUE_W +: KIND_W];
    assign rd_value  = rdata[VALUE_W-1:0];

    assign o_sts.last = (r_idx == SLOT_AW'(SLOTS - 1));

    // Decide the outcome of the captured request
    assign alloc_ok  = r_free && (r_counter != HANDLE_MAX) && (r_kind <= KIND_STR);
    assign access_ok = r_hit && (r_kind <= KIND_STR) && (r_hit_kind == r_kind);
    assign n_counter = r_counter + HANDLE_W'(1);

    always_comb begin
        we        = 1'b0;
        waddr     = r_hit_idx;
        wdata     = {r_hnd, r_hit_kind, r_wval & kind_mask(r_kind)};
        set_valid = 1'b0;
        clr_valid = 1'b0;
        n_rval    = '0;
        n_nh      = '0;
        n_fk      = '0;
        n_st      = ST_OK;
        unique case (r_req)
            REQ_CREATE: begin
                if (alloc_ok) begin
                    we        = i_cmd.finish;
                    waddr     = r_free_idx;
                    wdata     = {n_counter, r_kind, {VALUE_W{1'b0}}};
                    set_valid = i_cmd.finish;
                    n_nh      = n_counter;
                end else begin
                    n_st = ST_ALLOC;
                end
            end
            REQ_READ: begin
                if (access_ok) begin
                    n_rval = r_hit_val;
                end else begin
                    n_st = ST_MISS;
                end
            end
            REQ_WRITE: begin
                if (access_ok) begin
                    we = i_cmd.finish;
                end else begin
                    n_st = ST_MISS;
                end
            end
            REQ_FREE: begin
                clr_valid = i_cmd.finish && r_hit;
            end
            REQ_GETTYP: begin
                if (r_hit) begin
                    n_fk = r_hit_kind;
                end else begin
                    n_st = ST_MISS;
                end
            end
            default: begin
                n_st = ST_OK;
            end
        endcase
    end

    // Capture request and scan payload
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
        if (i_cmd.load) begin
            r_req  <= i_req_type;
            r_hnd  <= i_obj_handle;
            r_kind <= i_value_kind;
            r_wval <= i_write_value;
            r_idx  <= '0;
        end else if (i_cmd.scan) begin
            r_idx <= r_idx + SLOT_AW'(1);
        end
        // Record first matching slot and first free slot
        if (r_rd_vld && !r_hit && r_valid[r_cmp_idx] && (rd_handle == r_hnd)) begin
            r_hit_idx  <= r_cmp_idx;
            r_hit_kind <= rd_kind;
            r_hit_val  <= rd_value;
        end
        if (r_rd_vld && !r_free && !r_valid[r_cmp_idx]) begin
            r_free_idx <= r_cmp_idx;
        end
        if (i_cmd.finish) begin
            r_out_rval <= n_rval;
            r_out_nh   <= n_nh;
            r_out_fk   <= n_fk;
            r_out_st   <= n_st;
        end
    end

    // Control flags, valid bits, handle counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_valid   <= '0;
            r_counter <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld  <= i_cmd.scan;
            r_out_vld <= i_cmd.finish;
            if (i_cmd.load) begin
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else begin
                if (r_rd_vld && r_valid[r_cmp_idx] && (rd_handle == r_hnd)) begin
                    r_hit <= 1'b1;
                end
                if (r_rd_vld && !r_valid[r_cmp_idx]) begin
                    r_free <= 1'b1;
                end
            end
            if (set_valid) begin
                r_valid[r_free_idx] <= 1'b1;
                r_counter           <= n_counter;
            end
            if (clr_valid) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_vld;
    assign o_read_value = r_out_rval;
    assign o_new_handle = r_out_nh;
    assign o_found_kind = r_out_fk;
    assign o_status     = r_out_st;

`ifndef SYNTHESIS
    // Handle counter only holds or steps by one
    a_counter_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_counter == $past(r_counter)) ||
                 (r_counter == $past(r_counter) + HANDLE_W'(1)))
        else $error("handle counter moved by more than one");

    // A result beat follows a finish cycle
    a_beat_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_cmd.finish))
        else $error("result beat without finish");

    // A given-out handle comes only with ok status
    a_handle_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_new_handle != '0)) |-> (o_status == ST_OK))
        else $error("new handle with failure status");

    // Scan never overlaps the finish of a request
    a_scan_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.scan && i_cmd.finish))
        else $error("scan and finish in the same cycle");
`endif

endmodule

>>> hdl/typed_handle_store.sv
// Top level of the typed handle store: controller plus datapath.
// A request is taken when start is high and busy is low. Every slot lookup
// walks all SLOTS table entries through one RAM read port and one handle
// comparator, one entry a cycle. The scan is followed by a drain step for
// the registered RAM read and an apply step for the request. The result
// appears on the o_ ports for a single cycle with o_valid high, the cycle
// after the request is applied; the receiver cannot hold it off, so capture
// it on that cycle. A new request may be started in the apply cycle, so
// requests can run back to back. There is no clearing pass after reset:
// slot valid bits are cleared by reset itself.
module typed_handle_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ths_pkg::REQ_W-1:0]    i_req_type,
    input  logic [ths_pkg::HANDLE_W-1:0] i_obj_handle,
    input  logic [ths_pkg::KIND_W-1:0]   i_value_kind,
    input  logic [ths_pkg::VALUE_W-1:0]  i_write_value,
    output logic                         o_valid,
    output logic [ths_pkg::VALUE_W-1:0]  o_read_value,
    output logic [ths_pkg::HANDLE_W-1:0] o_new_handle,
    output logic [ths_pkg::KIND_W-1:0]   o_found_kind,
    output logic [ths_pkg::STATUS_W-1:0] o_status
);
    import ths_pkg::*;

    t_ths_cmd cmd;
    t_ths_sts sts;

    ths_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ths_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req_type),
        .i_obj_handle  (i_obj_handle),
        .i_value_kind  (i_value_kind),
        .i_write_value (i_write_value),
        .o_valid       (o_valid),
        .o_read_value  (o_read_value),
        .o_new_handle  (o_new_handle),
        .o_found_kind  (o_found_kind),
        .o_status      (o_status)
    );

endmodule
